### rtl/core/fifo_queue_with_search_assert.svh
// Assertion macros for the queue core.
// Needs i_clk and i_rst_n in the scope of each use.
`ifndef FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH
`define FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH

// same-cycle implication
`define FQS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FQS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/fqs_pkg.sv
// Shared types and constants for the queue with search.
// No dependencies.
`default_nettype none

package fqs_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int POS_W  = 5;

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_SEARCH = 2'd2
    } t_req_code;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [DATA_W-1:0] operand_value;
    } t_req;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] popped_value;
        logic [POS_W-1:0]         found_position;
    } t_rsp;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_ram_req;

endpackage

`default_nettype wire

### rtl/core/fqs_ram.sv
// Entry store: one write port, one read port, registered read data.
// Depends on fqs_pkg.
`default_nettype none

module fqs_ram (
    input  wire logic                            i_clk,
    input  wire fqs_pkg::t_ram_req               i_ram_req,
    output logic [fqs_pkg::DATA_W-1:0]           o_rd_data
);

    logic [fqs_pkg::DATA_W-1:0] r_mem [fqs_pkg::DEPTH];
    logic [fqs_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ram_req.wr_en) begin
            r_mem[i_ram_req.wr_addr] <= i_ram_req.wr_data;
        end
        if (i_ram_req.rd_en) begin
            r_rd_data <= r_mem[i_ram_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/core/fqs_ctrl.sv
// Sequencer: ring pointers, entry count, push/pop/search control, result word.
// Depends on fqs_pkg and fifo_queue_with_search_assert.svh.
`default_nettype none

`include "fifo_queue_with_search_assert.svh"

module fqs_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire fqs_pkg::t_req               i_req,
    output logic                             o_busy,
    output logic                             o_done,
    output fqs_pkg::t_rsp                    o_rsp,
    output fqs_pkg::t_ram_req                o_ram_req,
    input  wire logic [fqs_pkg::DATA_W-1:0]  i_rd_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_SCAN = 3'b100
    } t_state;

    t_state                      r_state, n_state;
    logic [fqs_pkg::ADDR_W-1:0]  r_head, n_head;
    logic [fqs_pkg::ADDR_W-1:0]  r_tail, n_tail;
    logic [fqs_pkg::CNT_W-1:0]   r_count, n_count;
    logic [fqs_pkg::ADDR_W-1:0]  r_slot, n_slot;
    logic [fqs_pkg::CNT_W-1:0]   r_k, n_k;
    logic [fqs_pkg::DATA_W-1:0]  r_key, n_key;
    logic                        r_done, n_done;
    fqs_pkg::t_rsp               r_rsp, n_rsp;

    logic                        w_full;
    logic                        w_empty;
    logic [fqs_pkg::CNT_W-1:0]   w_k_inc;
    logic [fqs_pkg::CNT_W+fqs_pkg::POS_W-1:0] w_pos_ext;

    function automatic logic [fqs_pkg::ADDR_W-1:0] ring_next(
        input logic [fqs_pkg::ADDR_W-1:0] slot
    );
        logic [fqs_pkg::ADDR_W-1:0] nxt;
        nxt = (slot == fqs_pkg::ADDR_W'(fqs_pkg::DEPTH - 1)) ?
              '0 : slot + fqs_pkg::ADDR_W'(1);
        return nxt;
    endfunction

    assign w_full    = (r_count == fqs_pkg::CNT_W'(fqs_pkg::DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_k_inc   = r_k + fqs_pkg::CNT_W'(1);
    assign w_pos_ext = {{fqs_pkg::POS_W{1'b0}}, w_k_inc};

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_slot  = r_slot;
        n_k     = r_k;
        n_key   = r_key;
        n_done  = 1'b0;
        n_rsp   = r_rsp;

        o_ram_req.wr_en   = 1'b0;
        o_ram_req.wr_addr = r_tail;
        o_ram_req.wr_data = i_req.operand_value;
        o_ram_req.rd_en   = 1'b0;
        o_ram_req.rd_addr = r_head;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_rsp        = '0;
                    n_rsp.status = fqs_pkg::ST_OK;
                    case (i_req.req_type)
                        fqs_pkg::REQ_PUSH: begin
                            n_done = 1'b1;
                            if (w_full) begin
                                n_rsp.status = fqs_pkg::ST_FULL;
                            end else begin
                                o_ram_req.wr_en = 1'b1;
                                n_tail  = ring_next(r_tail);
                                n_count = r_count + fqs_pkg::CNT_W'(1);
                            end
                        end
                        fqs_pkg::REQ_POP: begin
                            if (w_empty) begin
                                n_done       = 1'b1;
                                n_rsp.status = fqs_pkg::ST_EMPTY;
                            end else begin
                                o_ram_req.rd_en = 1'b1;
                                n_state = S_POP;
                            end
                        end
                        fqs_pkg::REQ_SEARCH: begin
                            if (w_empty) begin
                                n_done       = 1'b1;
                                n_rsp.status = fqs_pkg::ST_EMPTY;
                            end else begin
                                o_ram_req.rd_en = 1'b1;
                                n_slot  = r_head;
                                n_k     = '0;
                                n_key   = i_req.operand_value;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                n_done             = 1'b1;
                n_rsp.popped_value = i_rd_data;
                n_head             = ring_next(r_head);
                n_count            = r_count - fqs_pkg::CNT_W'(1);
                n_state            = S_IDLE;
            end
            S_SCAN: begin
                if (i_rd_data == r_key) begin
                    n_done               = 1'b1;
                    n_rsp.status         = fqs_pkg::ST_OK;
                    n_rsp.found_position = w_pos_ext[fqs_pkg::POS_W-1:0];
                    n_state              = S_IDLE;
                end else if (w_k_inc == r_count) begin
                    n_done       = 1'b1;
                    n_rsp.status = fqs_pkg::ST_NOT_FOUND;
                    n_state      = S_IDLE;
                end else begin
                    o_ram_req.rd_en   = 1'b1;
                    o_ram_req.rd_addr = ring_next(r_slot);
                    n_slot            = ring_next(r_slot);
                    n_k               = w_k_inc;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_k    <= n_k;
        r_key  <= n_key;
        r_rsp  <= n_rsp;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    `FQS_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= fqs_pkg::CNT_W'(fqs_pkg::DEPTH), "entry count above depth")
    `FQS_ASSERT_IMPL(a_scan_in_range, r_state == S_SCAN, (r_k < r_count) && !w_empty, "scan index past held entries")
    `FQS_ASSERT_NEXT(a_pop_done, r_state == S_POP, r_done && (r_rsp.status == fqs_pkg::ST_OK), "pop read without result word")
    `FQS_ASSERT_IMPL(a_fail_zero, r_done && (r_rsp.status != fqs_pkg::ST_OK), (r_rsp.popped_value == '0) && (r_rsp.found_position == '0), "failed request carries data")

endmodule

`default_nettype wire

### rtl/core/fifo_queue_with_search.sv
// Top level of the queue with search: sequencer plus entry store.
// Depends on fqs_pkg, fqs_ctrl and fqs_ram.
//
//  channel   | ports                   | handshake
//  ----------+-------------------------+-----------------------------------
//  request   | start, busy, i_req      | taken at edge with start && !busy
//  result    | o_done, o_rsp           | one-cycle strobe, always taken
//
// Push and unused codes: result strobe in the next cycle, busy stays low.
// Pop: goes through S_POP, for the registered read of the entry store.
// Search: stays in S_SCAN while it walks the entries; the store's single read port feeds one compare a cycle.
// Failed pushes and requests on an empty queue answer straight from idle; busy stays low.
// Reset clears pointers, count and strobe; the store is not cleared.
`default_nettype none

module fifo_queue_with_search (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire fqs_pkg::t_req  i_req,
    output logic                busy,
    output logic                o_done,
    output fqs_pkg::t_rsp       o_rsp
);

    fqs_pkg::t_ram_req          w_ram_req;
    logic [fqs_pkg::DATA_W-1:0] w_rd_data;

    fqs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_req     (i_req),
        .o_busy    (busy),
        .o_done    (o_done),
        .o_rsp     (o_rsp),
        .o_ram_req (w_ram_req),
        .i_rd_data (w_rd_data)
    );

    fqs_ram u_ram (
        .i_clk     (i_clk),
        .i_ram_req (w_ram_req),
        .o_rd_data (w_rd_data)
    );

endmodule

`default_nettype wire
